### rtl/itp_pkg.sv
// ----------------------------------------------------------------------------
// itp_pkg
// Shared types, character codes and helpers for the infix to postfix
// converter.
// ----------------------------------------------------------------------------
package itp_pkg;

    localparam int STACK_DEPTH = 32;
    localparam int STK_IDX_W   = $clog2(STACK_DEPTH);
    localparam int STK_CNT_W   = $clog2(STACK_DEPTH + 1);

    localparam int QUEUE_DEPTH = 2;
    localparam int Q_IDX_W     = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int Q_CNT_W     = $clog2(QUEUE_DEPTH + 1);

    localparam logic [7:0] CH_CARET  = 8'h5E;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_PLUS   = 8'h2B;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_RPAREN = 8'h29;
    localparam logic [7:0] CH_NUL    = 8'h00;

    localparam logic [1:0] PREC_NONE = 2'd0;
    localparam logic [1:0] PREC_ADD  = 2'd1;
    localparam logic [1:0] PREC_MUL  = 2'd2;
    localparam logic [1:0] PREC_POW  = 2'd3;

    typedef enum logic [2:0] {
        K_NONE,
        K_PASS,
        K_LPAREN,
        K_RPAREN,
        K_OP
    } t_kind;

    typedef struct packed {
        t_kind      kind;
        logic [7:0] ch;
        logic [1:0] prec;
        logic       last;
    } t_cmd;

    typedef enum logic {
        S_CHAR,
        S_FLUSH
    } t_state;

    function automatic logic [1:0] prec_of(input logic [7:0] c);
        logic [1:0] p;
        p = PREC_NONE;
        if (c == CH_CARET)
            p = PREC_POW;
        else if (c == CH_STAR || c == CH_SLASH)
            p = PREC_MUL;
        else if (c == CH_PLUS || c == CH_MINUS)
            p = PREC_ADD;
        return p;
    endfunction

endpackage

### rtl/itp_front.sv
// ----------------------------------------------------------------------------
// itp_front
// Input side: classifies each accepted character into a stack command and
// drops beats that carry no work.
// ----------------------------------------------------------------------------
module itp_front (
    input  logic            i_in_valid,
    input  logic [7:0]      i_in_char,
    input  logic            i_char_present,
    input  logic            i_end_of_expr,
    output logic            o_in_stall,
    input  logic            i_q_full,
    output logic            o_q_push,
    output itp_pkg::t_cmd   o_q_cmd
);
    import itp_pkg::*;

    logic       is_alnum;
    logic [1:0] prec;
    t_kind      kind;

    always_comb begin
        is_alnum = (i_in_char >= 8'h30 && i_in_char <= 8'h39) ||
                   (i_in_char >= 8'h41 && i_in_char <= 8'h5A) ||
                   (i_in_char >= 8'h61 && i_in_char <= 8'h7A);
        prec = prec_of(i_in_char);
        kind = K_NONE;
        if (i_char_present) begin
            if (is_alnum)
                kind = K_PASS;
            else if (i_in_char == CH_LPAREN)
                kind = K_LPAREN;
            else if (i_in_char == CH_RPAREN)
                kind = K_RPAREN;
            else if (prec != PREC_NONE)
                kind = K_OP;
        end
    end

    assign o_in_stall   = i_q_full;
    // drop beats that neither carry a character of use nor close the expression
    assign o_q_push     = i_in_valid && !i_q_full && (kind != K_NONE || i_end_of_expr);
    assign o_q_cmd.kind = kind;
    assign o_q_cmd.ch   = i_in_char;
    assign o_q_cmd.prec = prec;
    assign o_q_cmd.last = i_end_of_expr;

endmodule

### rtl/itp_queue.sv
// ----------------------------------------------------------------------------
// itp_queue
// Short command queue between the classifier and the stack sequencer.
// ----------------------------------------------------------------------------
module itp_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  itp_pkg::t_cmd   i_push_cmd,
    output logic            o_full,
    output logic            o_valid,
    output itp_pkg::t_cmd   o_cmd,
    input  logic            i_pop
);
    import itp_pkg::*;

    t_cmd               r_mem [QUEUE_DEPTH];
    logic [Q_IDX_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [Q_IDX_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [Q_CNT_W-1:0] r_count,  n_count;

    function automatic logic [Q_IDX_W-1:0] ptr_inc(input logic [Q_IDX_W-1:0] p);
        logic [Q_IDX_W-1:0] r;
        if (p == Q_IDX_W'(QUEUE_DEPTH - 1))
            r = '0;
        else
            r = p + Q_IDX_W'(1);
        return r;
    endfunction

    assign o_full  = (r_count == Q_CNT_W'(QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_cmd   = r_mem[r_rd_ptr];

    always_comb begin
        n_wr_ptr = i_push ? ptr_inc(r_wr_ptr) : r_wr_ptr;
        n_rd_ptr = i_pop  ? ptr_inc(r_rd_ptr) : r_rd_ptr;
        n_count  = r_count;
        if (i_push && !i_pop)
            n_count = r_count + Q_CNT_W'(1);
        else if (!i_push && i_pop)
            n_count = r_count - Q_CNT_W'(1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push)
            r_mem[r_wr_ptr] <= i_push_cmd;
    end

endmodule

### rtl/itp_back.sv
// ----------------------------------------------------------------------------
// itp_back
// Stack sequencer: works one command at a time on the operator stack into an
// output register, one push, pop or emitted beat per cycle unless stalled.
// ----------------------------------------------------------------------------
module itp_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_cmd_valid,
    input  itp_pkg::t_cmd   i_cmd,
    output logic            o_cmd_pop,
    output logic            o_out_valid,
    input  logic            i_out_stall,
    output logic [7:0]      o_out_char,
    output logic            o_out_present,
    output logic            o_out_last,
    output logic            o_overflow_seen
);
    import itp_pkg::*;

    logic [7:0]           r_stack [STACK_DEPTH];
    logic [7:0]           r_top;
    logic [STK_CNT_W-1:0] r_count, n_count;
    logic                 r_ovf, n_ovf;
    t_state               r_state, n_state;

    logic                 r_out_valid;
    logic [7:0]           r_out_char;
    logic                 r_out_present;
    logic                 r_out_last;
    logic                 r_out_ovf;

    logic                 out_free;
    logic                 has_entry;
    logic                 stack_full;
    logic                 top_lparen;
    logic [1:0]           top_prec;
    logic                 push;
    logic                 pop;
    logic                 done;
    logic                 emit;
    logic [7:0]           e_char;
    logic                 e_present;
    logic                 e_last;
    logic                 e_ovf;
    logic                 wr_en;
    logic [STK_IDX_W-1:0] rd_addr;

    assign out_free   = !r_out_valid || !i_out_stall;
    assign has_entry  = (r_count != '0);
    assign stack_full = (r_count == STK_CNT_W'(STACK_DEPTH));
    assign top_lparen = (r_top == CH_LPAREN);
    assign top_prec   = prec_of(r_top);
    assign wr_en      = push && !stack_full;

    always_comb begin
        n_state   = r_state;
        push      = 1'b0;
        pop       = 1'b0;
        done      = 1'b0;
        emit      = 1'b0;
        e_char    = r_top;
        e_present = 1'b1;
        e_last    = 1'b0;
        e_ovf     = 1'b0;
        o_cmd_pop = 1'b0;
        n_ovf     = r_ovf;

        unique case (r_state)
            S_CHAR: begin
                if (i_cmd_valid) begin
                    unique case (i_cmd.kind)
                        K_PASS: begin
                            if (out_free) begin
                                emit   = 1'b1;
                                e_char = i_cmd.ch;
                                done   = 1'b1;
                            end
                        end
                        K_LPAREN: begin
                            push = 1'b1;
                            done = 1'b1;
                        end
                        K_RPAREN: begin
                            if (!has_entry) begin
                                done = 1'b1;
                            end else if (top_lparen) begin
                                pop  = 1'b1;
                                done = 1'b1;
                            end else if (out_free) begin
                                emit = 1'b1;
                                pop  = 1'b1;
                            end
                        end
                        K_OP: begin
                            if (has_entry && top_prec >= i_cmd.prec) begin
                                if (out_free) begin
                                    emit = 1'b1;
                                    pop  = 1'b1;
                                end
                            end else begin
                                push = 1'b1;
                                done = 1'b1;
                            end
                        end
                        K_NONE: begin
                            done = 1'b1;
                        end
                        default: begin
                            done = 1'b1;
                        end
                    endcase
                    if (done) begin
                        if (i_cmd.last)
                            n_state = S_FLUSH;
                        else
                            o_cmd_pop = 1'b1;
                    end
                end
            end
            S_FLUSH: begin
                if (has_entry) begin
                    // unmatched '(' is dropped silently
                    if (top_lparen) begin
                        pop = 1'b1;
                    end else if (out_free) begin
                        emit = 1'b1;
                        pop  = 1'b1;
                    end
                end else if (out_free) begin
                    emit      = 1'b1;
                    e_char    = CH_NUL;
                    e_present = 1'b0;
                    e_last    = 1'b1;
                    e_ovf     = r_ovf;
                    n_ovf     = 1'b0;
                    o_cmd_pop = 1'b1;
                    n_state   = S_CHAR;
                end
            end
            default: begin
                n_state = S_CHAR;
            end
        endcase

        if (push && stack_full)
            n_ovf = 1'b1;

        n_count = r_count;
        if (wr_en)
            n_count = r_count + STK_CNT_W'(1);
        else if (pop)
            n_count = r_count - STK_CNT_W'(1);

        // read the entry that becomes top after this cycle
        if (n_count == '0)
            rd_addr = '0;
        else
            rd_addr = STK_IDX_W'(n_count - STK_CNT_W'(1));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CHAR;
            r_count     <= '0;
            r_ovf       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_ovf   <= n_ovf;
            if (emit)
                r_out_valid <= 1'b1;
            else if (!i_out_stall)
                r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_out_char    <= e_char;
            r_out_present <= e_present;
            r_out_last    <= e_last;
            r_out_ovf     <= e_ovf;
        end
    end

    // stack memory: one write port, one registered read port; a push bypasses
    always_ff @(posedge i_clk) begin
        if (wr_en)
            r_stack[r_count[STK_IDX_W-1:0]] <= i_cmd.ch;
        if (wr_en)
            r_top <= i_cmd.ch;
        else
            r_top <= r_stack[rd_addr];
    end

    assign o_out_valid     = r_out_valid;
    assign o_out_char      = r_out_char;
    assign o_out_present   = r_out_present;
    assign o_out_last      = r_out_last;
    assign o_overflow_seen = r_out_ovf;

endmodule

### rtl/infix_to_postfix_converter.sv
// ----------------------------------------------------------------------------
// infix_to_postfix_converter
// Shunting-yard conversion of an infix character stream to postfix order.
// ----------------------------------------------------------------------------
// Characters enter one beat at a time, are classified at the input and wait
// in a two-entry command queue; a stack sequencer then works each command
// against a 32-entry operator stack held in a memory with a registered top.
// The sequencer makes one stack step per cycle unless the output stalls: a
// letter or digit, a push or a discarded parenthesis is one step, every
// operator popped and emitted is one more, and the end of an expression
// pops each stacked entry in turn before the closing end marker. Beats with
// no character and no end flag, and characters outside the operator,
// parenthesis and alphanumeric sets, are dropped. A push to a full stack is
// lost and flagged on the end marker.
// ----------------------------------------------------------------------------
module infix_to_postfix_converter (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  logic [7:0] i_in_char,
    input  logic       i_char_present,
    input  logic       i_end_of_expr,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output logic [7:0] o_out_char,
    output logic       o_out_present,
    output logic       o_out_last,
    output logic       o_overflow_seen
);
    import itp_pkg::*;

    logic q_full;
    logic q_push;
    t_cmd q_in_cmd;
    logic q_valid;
    t_cmd q_out_cmd;
    logic q_pop;

    itp_front u_front (
        .i_in_valid     (i_in_valid),
        .i_in_char      (i_in_char),
        .i_char_present (i_char_present),
        .i_end_of_expr  (i_end_of_expr),
        .o_in_stall     (o_in_stall),
        .i_q_full       (q_full),
        .o_q_push       (q_push),
        .o_q_cmd        (q_in_cmd)
    );

    itp_queue u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (q_push),
        .i_push_cmd (q_in_cmd),
        .o_full     (q_full),
        .o_valid    (q_valid),
        .o_cmd      (q_out_cmd),
        .i_pop      (q_pop)
    );

    itp_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd_valid     (q_valid),
        .i_cmd           (q_out_cmd),
        .o_cmd_pop       (q_pop),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_out_char      (o_out_char),
        .o_out_present   (o_out_present),
        .o_out_last      (o_out_last),
        .o_overflow_seen (o_overflow_seen)
    );

endmodule
